@@ hw/rtl/mmss_pkg.sv @@
// Shared types and codes for the min/max sorted store.
// Used by mmss_cell and min_max_sorted_store; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mmss_pkg;

  localparam int unsigned MMSS_CAPACITY = 64;
  localparam int unsigned VAL_W         = 10;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned STAT_W        = 2;
  localparam int unsigned DATA_W        = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MIN       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MAX       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP_ASC  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP_DESC = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Row operation applied to every cell in the same cycle
  typedef struct packed {
    logic insert;
    logic rot_left;
    logic rot_right;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/mmss_cell.sv @@
// One cell of the sorted row: holds a single value, does ordered insertion
// and ring rotation with its neighbours. Depends on mmss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmss_cell import mmss_pkg::*; (
  input  wire logic             clk_i,
  input  wire cell_ctl_t        ctl_i,
  input  wire logic [VAL_W-1:0] ins_val_i,
  input  wire logic             occ_i,       // cell holds a stored value
  input  wire logic             last_i,      // cell holds the largest value
  input  wire logic [VAL_W-1:0] left_val_i,  // cell 0: tail of the ring
  input  wire logic             left_gt_i,   // cell 0: tied low
  input  wire logic [VAL_W-1:0] right_val_i,
  input  wire logic [VAL_W-1:0] head_val_i,  // value of cell 0
  output logic [VAL_W-1:0]      val_o,
  output logic                  gt_o
);

  logic [VAL_W-1:0] val_q, val_d;

  // Empty cells count as above any value, so the row stays sorted
  assign gt_o  = !occ_i || (val_q > ins_val_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.insert) begin
      if (gt_o) begin
        val_d = left_gt_i ? left_val_i : ins_val_i;
      end
    end else if (ctl_i.rot_left) begin
      val_d = last_i ? head_val_i : right_val_i;
    end else if (ctl_i.rot_right) begin
      val_d = left_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/min_max_sorted_store.sv @@
// Min/max sorted store: top level with the cell row, command control and
// output register. Depends on mmss_pkg and mmss_cell.
// A result is registered in the cycle after its input transfer; a dump first
// enters the dump state, then loads each value into the output register.
// Insert, min and max are taken back to back while the output drains. A dump
// holds input off; one value a cycle leaves as the cell row rotates, unless stalled.
// Reset clears the entry count, control state and output valid; cells are not reset.
`timescale 1ns / 1ps
`default_nettype none

module min_max_sorted_store import mmss_pkg::*; #(
  parameter int unsigned CAPACITY = MMSS_CAPACITY
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,   // [9:0] value, rest zero
  input  wire logic [CMD_W-1:0]  s_axis_tuser,   // [2:0] command
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [DATA_W-1:0]      m_axis_tdata,   // [9:0] value_res, rest zero
  output logic [STAT_W-1:0]      m_axis_tuser,   // [1:0] status
  output logic                   m_axis_tlast
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic             state_q, state_d;
  logic             desc_q, desc_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    count_q, count_d;

  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_val_q;
  logic [STAT_W-1:0] out_stat_q;
  logic             out_last_q;

  logic             out_load;
  logic [VAL_W-1:0] ld_val;
  logic [STAT_W-1:0] ld_stat;
  logic             ld_last;

  cell_ctl_t        ctl;
  logic [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_gt, cell_occ, cell_last;
  logic [VAL_W-1:0] head_val, tail_val;

  logic             slot_free, in_fire, dump_fire, empty, full, idx_last;
  logic [CMD_W-1:0] cmd;
  logic [VAL_W-1:0] in_val;

  assign cmd      = s_axis_tuser;
  assign in_val   = s_axis_tdata[VAL_W-1:0];
  assign empty    = (count_q == '0);
  assign full     = (count_q >= CW'(CAPACITY));
  assign idx_last = (CW'(idx_q) == (count_q - CW'(1)));

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && slot_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign dump_fire     = (state_q == S_DUMP) && slot_free;

  assign ctl.insert    = in_fire && (cmd == CMD_INSERT) && !full;
  assign ctl.rot_left  = dump_fire && !desc_q;
  assign ctl.rot_right = dump_fire && desc_q;

  assign head_val = cell_val[0];

  // Largest stored value: select of the last occupied cell
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_last[i]) begin
        tail_val = tail_val | cell_val[i];
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign cell_occ[g]  = (CW'(g) < count_q);
    assign cell_last[g] = (CW'(g) == (count_q - CW'(1))) && !empty;

    mmss_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .ins_val_i  (in_val),
      .occ_i      (cell_occ[g]),
      .last_i     (cell_last[g]),
      .left_val_i ((g == 0) ? tail_val : cell_val[(g == 0) ? 0 : g - 1]),
      .left_gt_i  ((g == 0) ? 1'b0 : cell_gt[(g == 0) ? 0 : g - 1]),
      .right_val_i(cell_val[(g == CAPACITY - 1) ? g : g + 1]),
      .head_val_i (head_val),
      .val_o      (cell_val[g]),
      .gt_o       (cell_gt[g])
    );
  end

  always_comb begin
    state_d  = state_q;
    desc_d   = desc_q;
    idx_d    = idx_q;
    count_d  = count_q;
    out_load = 1'b0;
    ld_val   = '0;
    ld_stat  = STAT_OK;
    ld_last  = 1'b1;

    if (in_fire) begin
      case (cmd)
        CMD_INSERT: begin
          out_load = 1'b1;
          if (full) begin
            ld_stat = STAT_FULL;
          end else begin
            count_d = count_q + CW'(1);
          end
        end
        CMD_MIN, CMD_MAX, CMD_DUMP_ASC, CMD_DUMP_DESC: begin
          if (empty) begin
            out_load = 1'b1;
            ld_stat  = STAT_EMPTY;
          end else if (cmd == CMD_MIN) begin
            out_load = 1'b1;
            ld_val   = head_val;
          end else if (cmd == CMD_MAX) begin
            out_load = 1'b1;
            ld_val   = tail_val;
          end else begin
            state_d = S_DUMP;
            desc_d  = (cmd == CMD_DUMP_DESC);
            idx_d   = '0;
          end
        end
        default: begin
          // unused codes: dropped without a result
        end
      endcase
    end

    if (dump_fire) begin
      out_load = 1'b1;
      ld_val   = desc_q ? tail_val : head_val;
      ld_last  = idx_last;
      idx_d    = idx_q + IW'(1);
      if (idx_last) begin
        state_d = S_IDLE;
      end
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    idx_q  <= idx_d;
    if (out_load) begin
      out_val_q  <= ld_val;
      out_stat_q <= ld_stat;
      out_last_q <= ld_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(DATA_W - VAL_W){1'b0}}, out_val_q};
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking bench for min_max_sorted_store: directed and random command streams
// are checked against a sorted-queue model of the store. Depends on mmss_pkg.
`timescale 1ns / 1ps

module tb;
  import mmss_pkg::*;

  localparam int unsigned CAPACITY    = MMSS_CAPACITY;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned MAX_PRINTS  = 40;

  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] mark;
  } request_t;

  typedef struct {
    logic [VAL_W-1:0]  mark;
    logic [STAT_W-1:0] status;
    logic              last;
  } response_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;   // [9:0] value, rest zero
  logic [CMD_W-1:0]  s_axis_tuser = '0;   // [2:0] command
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // [9:0] value_res, rest zero
  logic [STAT_W-1:0] m_axis_tuser;        // [1:0] status
  logic              m_axis_tlast;

  request_t         pending_requests[$];
  response_t        expected_responses[$];
  logic [VAL_W-1:0] model_marks[$];       // ascending, mirrors the store

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned requests_taken = 0;
  int unsigned responses_seen = 0;
  int unsigned full_drops     = 0;
  int unsigned dumps_taken    = 0;

  min_max_sorted_store #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatches++;
  endtask

  function automatic response_t make_response(input logic [VAL_W-1:0] mark,
                                              input logic [STAT_W-1:0] status,
                                              input logic last);
    response_t r;
    r.mark   = mark;
    r.status = status;
    r.last   = last;
    return r;
  endfunction

  // Appends one expectation at the tail of the response queue.
  task automatic expect_response(input logic [VAL_W-1:0] mark,
                                 input logic [STAT_W-1:0] status,
                                 input logic last);
    expected_responses.insert(expected_responses.size(), make_response(mark, status, last));
  endtask

  // Updates the sorted model and queues the responses one request causes.
  task automatic predict_store_response(input logic [CMD_W-1:0] cmd,
                                        input logic [VAL_W-1:0] mark);
    int n;
    int pos;
    n = model_marks.size();
    case (cmd)
      CMD_INSERT: begin
        if (n >= CAPACITY) begin
          full_drops++;
          expect_response('0, STAT_FULL, 1'b1);
        end else begin
          pos = n;
          for (int i = 0; i < n; i++) begin
            if (model_marks[i] > mark && pos == n) pos = i;
          end
          model_marks.insert(pos, mark);
          expect_response('0, STAT_OK, 1'b1);
        end
      end
      CMD_MIN, CMD_MAX, CMD_DUMP_ASC, CMD_DUMP_DESC: begin
        if (cmd == CMD_DUMP_ASC || cmd == CMD_DUMP_DESC) dumps_taken++;
        if (n == 0) begin
          expect_response('0, STAT_EMPTY, 1'b1);
        end else if (cmd == CMD_MIN) begin
          expect_response(model_marks[0], STAT_OK, 1'b1);
        end else if (cmd == CMD_MAX) begin
          expect_response(model_marks[n-1], STAT_OK, 1'b1);
        end else begin
          for (int k = 0; k < n; k++) begin
            expect_response((cmd == CMD_DUMP_ASC) ? model_marks[k] : model_marks[n-1-k],
                            STAT_OK, k == n - 1);
          end
        end
      end
      default: ;  // reserved codes: no response, no state change
    endcase
  endtask

  // Driver: presents queued requests, holding each until its transfer.
  always @(posedge clk_i) begin
    request_t req;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_store_response(s_axis_tuser, s_axis_tdata[VAL_W-1:0]);
        requests_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= req.cmd;
          s_axis_tdata  <= {{(DATA_W-VAL_W){1'b0}}, req.mark};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: every response transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin
    response_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      responses_seen++;
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response value=%0d status=%0d last=%0b",
                                  m_axis_tdata[VAL_W-1:0], m_axis_tuser, m_axis_tlast));
      end else begin
        exp_r = expected_responses.pop_front();
        if (m_axis_tdata[VAL_W-1:0] !== exp_r.mark || m_axis_tuser !== exp_r.status ||
            m_axis_tlast !== exp_r.last) begin
          report_mismatch($sformatf("got value=%0d status=%0d last=%0b, want %0d/%0d/%0b",
                                    m_axis_tdata[VAL_W-1:0], m_axis_tuser, m_axis_tlast,
                                    exp_r.mark, exp_r.status, exp_r.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_responses.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] mark);
    request_t r;
    r.cmd  = cmd;
    r.mark = mark;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  function automatic logic [VAL_W-1:0] pick_mark();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) return ($urandom_range(0, 1) != 0) ? {VAL_W{1'b1}} : '0;
    if (sel < 55) return VAL_W'($urandom_range(500, 507));  // narrow window for duplicates
    return VAL_W'($urandom);
  endfunction

  // Random mix; reserved codes come on top of the count.
  task automatic queue_random_requests(input int unsigned count);
    int unsigned made;
    int unsigned sel;
    made = 0;
    while (made < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 32)       queue_request(CMD_INSERT, pick_mark());
      else if (sel < 48)  queue_request(CMD_MIN, VAL_W'($urandom));
      else if (sel < 64)  queue_request(CMD_MAX, VAL_W'($urandom));
      else if (sel < 77)  queue_request(CMD_DUMP_ASC, VAL_W'($urandom));
      else if (sel < 90)  queue_request(CMD_DUMP_DESC, VAL_W'($urandom));
      else if (sel < 94)  queue_request(CMD_RSVD_5, VAL_W'($urandom));
      else if (sel < 97)  queue_request(CMD_RSVD_6, VAL_W'($urandom));
      else                queue_request(CMD_RSVD_7, VAL_W'($urandom));
      if (sel < 90) made++;
    end
  endtask

  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_responses.size() != 0)
      @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty store: queries, dumps and ignored codes
    queue_request(CMD_MIN, '0);
    queue_request(CMD_MAX, {VAL_W{1'b1}});
    queue_request(CMD_DUMP_ASC, 10'd341);
    queue_request(CMD_DUMP_DESC, 10'd682);
    queue_request(CMD_RSVD_5, {VAL_W{1'b1}});
    queue_request(CMD_RSVD_6, '0);
    queue_request(CMD_RSVD_7, 10'd682);
    // extremes and duplicates
    queue_request(CMD_INSERT, {VAL_W{1'b1}});
    queue_request(CMD_INSERT, '0);
    queue_request(CMD_INSERT, 10'd512);
    queue_request(CMD_INSERT, '0);
    queue_request(CMD_INSERT, {VAL_W{1'b1}});
    queue_request(CMD_MIN, 10'd341);
    queue_request(CMD_MAX, 10'd682);
    queue_request(CMD_DUMP_ASC, '0);
    queue_request(CMD_DUMP_DESC, '0);
    queue_request(CMD_INSERT, 10'd341);
    queue_request(CMD_INSERT, 10'd682);
    queue_request(CMD_RSVD_7, 10'd341);
    queue_request(CMD_DUMP_ASC, {VAL_W{1'b1}});
    queue_request(CMD_DUMP_DESC, {VAL_W{1'b1}});
    wait_until_drained();

    // the store never shrinks, so it fills in a later random phase and then stays full
    queue_random_requests(105);
    wait_until_drained();

    send_idle_pct = 63;
    queue_random_requests(105);
    wait_until_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 63;
    queue_random_requests(105);
    wait_until_drained();

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    queue_random_requests(105);
    wait_until_drained();

    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d requests (%0d dumps, %0d inserts refused as full), %0d responses",
             requests_taken, dumps_taken, full_drops, responses_seen);
    $display("Store held %0d of %0d entries at the end, %0d mismatches",
             model_marks.size(), CAPACITY, mismatches);
    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
